/* sv/hmt_pkg.sv */
// Shared types and constants of the heartbeat membership table.
`default_nettype none
package hmt_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int MAX_RESULTS = 32;
  localparam int CNT_W = $clog2(MAX_RESULTS + 1);

  // Input opcodes
  localparam logic [1:0] OP_JOIN_REQ = 2'd0;
  localparam logic [1:0] OP_JOIN_REP = 2'd1;
  localparam logic [1:0] OP_HEARTBEAT = 2'd2;
  localparam logic [1:0] OP_TICK = 2'd3;

  // Result kinds
  localparam logic [1:0] EV_REPLY = 2'd0;
  localparam logic [1:0] EV_ADDED = 2'd1;
  localparam logic [1:0] EV_REMOVED = 2'd2;
  localparam logic [1:0] EV_BEAT = 2'd3;

  // Probe modes
  localparam logic [1:0] MODE_SEARCH = 2'd0;
  localparam logic [1:0] MODE_EXPIRE = 2'd1;
  localparam logic [1:0] MODE_BEAT = 2'd2;

  // Register indexes
  localparam logic [1:0] REG_OWN_ID = 2'd0;
  localparam logic [1:0] REG_OWN_PORT = 2'd1;
  localparam logic [1:0] REG_TIMEOUT = 2'd2;
  localparam logic [1:0] REG_INTRO = 2'd3;

  localparam logic [15:0] TIMEOUT_RESET = 16'd20;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] sender_id;
    logic [15:0] sender_port;
    logic [31:0] sender_heartbeat;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [31:0] dest_id;
    logic [15:0] dest_port;
    logic [31:0] beat_value;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic        valid;
    logic [1:0]  mode;
    logic [31:0] id;
    logic [15:0] port;
    logic [31:0] beat;
    logic        found;
    logic        free_seen;
  } probe_t;

  typedef struct packed {
    logic        req;
    logic [1:0]  kind;
    logic [31:0] id;
    logic [15:0] port;
  } emit_t;

  typedef struct packed {
    logic        en;
    logic [31:0] id;
    logic [15:0] port;
    logic [31:0] beat;
  } insert_t;

endpackage
`default_nettype wire

/* sv/heartbeat_membership_table_top.sv */
// Top level of the heartbeat membership table: control, registers, cell chain.
// A message runs one search pass (a join request sends its reply first); a tick in the
// group or at the introducer runs one pass per phase (expire, search, beat), and any
// other tick runs no pass.
// Throughput: one word at a time; each pass walks the probe one cell per cycle.
// Output stalls hold the probe in place whenever a result cannot be stored.
// Reset clears all valid bits, time, own heartbeat, group flag and registers (timeout resets to 20).
`default_nettype none
module heartbeat_membership_table_top #(
  parameter int TableDepth = hmt_pkg::TABLE_DEPTH
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 psel,
  input  wire                 penable,
  input  wire                 pwrite,
  input  wire  [3:0]          paddr,
  input  wire  [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  input  wire                 in_valid_i,
  output logic                in_stall_o,
  input  hmt_pkg::in_word_t   in_word_i,
  output logic                out_valid_o,
  input  wire                 out_stall_i,
  output hmt_pkg::out_word_t  out_word_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_REPLY  = 3'd1;
  localparam logic [2:0] S_SEARCH = 3'd2;
  localparam logic [2:0] S_INSERT = 3'd3;
  localparam logic [2:0] S_EXPIRE = 3'd4;
  localparam logic [2:0] S_BEAT   = 3'd5;
  localparam logic [2:0] S_FIN    = 3'd6;

  // configuration registers
  logic [31:0] own_id_q;
  logic [15:0] own_port_q;
  logic [15:0] timeout_q;
  logic        intro_q;
  logic        cfg_wr;

  // control and state
  logic [2:0]              state_q, state_d;
  logic                    launched_q, launched_d;
  hmt_pkg::in_word_t       item_q;
  logic                    tick_q;
  logic                    ins_need_q, ins_need_d;
  logic [hmt_pkg::CNT_W-1:0] cnt_q;
  logic [31:0]             time_q, time_d;
  logic [31:0]             own_beat_q, own_beat_d;
  logic                    in_group_q, in_group_d;
  logic                    accept;

  // chain
  hmt_pkg::probe_t  probe_head;
  hmt_pkg::probe_t  probe [TableDepth+1];
  hmt_pkg::emit_t   cell_emit [TableDepth];
  hmt_pkg::emit_t   chain_emit;
  hmt_pkg::insert_t ins;
  logic             adv;
  logic [TableDepth-1:0] probe_vec;

  // result path
  logic               ctrl_req;
  hmt_pkg::out_word_t emit_word;
  logic               emit_req, cap, emit_ok, push, fin, push_ok, fin_ok;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_id_q   <= '0;
      own_port_q <= '0;
      timeout_q  <= hmt_pkg::TIMEOUT_RESET;
      intro_q    <= 1'b0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        hmt_pkg::REG_OWN_ID:   own_id_q   <= pwdata;
        hmt_pkg::REG_OWN_PORT: own_port_q <= pwdata[15:0];
        hmt_pkg::REG_TIMEOUT:  timeout_q  <= pwdata[15:0];
        hmt_pkg::REG_INTRO:    intro_q    <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      hmt_pkg::REG_OWN_ID:   prdata = own_id_q;
      hmt_pkg::REG_OWN_PORT: prdata = {16'd0, own_port_q};
      hmt_pkg::REG_TIMEOUT:  prdata = {16'd0, timeout_q};
      hmt_pkg::REG_INTRO:    prdata = {31'd0, intro_q};
      default:               prdata = '0;
    endcase
  end

  // ---------------- cell chain ----------------
  // Launch a probe into the first cell once per pass; it walks one cell a cycle unless a result stall holds it.
  always_comb begin
    probe_head           = '0;
    probe_head.valid     = !launched_q &&
                           (state_q == S_SEARCH || state_q == S_EXPIRE || state_q == S_BEAT);
    probe_head.id        = own_id_q;
    probe_head.port      = own_port_q;
    probe_head.beat      = own_beat_q;
    case (state_q)
      S_SEARCH: begin
        probe_head.mode = hmt_pkg::MODE_SEARCH;
        if (!tick_q) begin
          probe_head.id   = item_q.sender_id;
          probe_head.port = item_q.sender_port;
          probe_head.beat = item_q.sender_heartbeat;
        end
      end
      S_EXPIRE: probe_head.mode = hmt_pkg::MODE_EXPIRE;
      default:  probe_head.mode = hmt_pkg::MODE_BEAT;
    endcase
  end

  assign probe[0] = probe_head;

  for (genvar k = 0; k < TableDepth; k++) begin : g_cell
    hmt_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .adv_i     (adv),
      .probe_i   (probe[k]),
      .probe_o   (probe[k+1]),
      .time_i    (time_q),
      .timeout_i (timeout_q),
      .ins_i     (ins),
      .emit_o    (cell_emit[k])
    );
    assign probe_vec[k] = probe[k+1].valid;
  end

  // Only the cell that holds the probe can request, so OR the requests together.
  always_comb begin
    chain_emit = '0;
    for (int k = 0; k < TableDepth; k++) begin
      if (cell_emit[k].req) begin
        chain_emit = chain_emit | cell_emit[k];
      end
    end
  end

  // ---------------- result path ----------------
  assign cap     = cnt_q >= hmt_pkg::CNT_W'(hmt_pkg::MAX_RESULTS);
  assign emit_ok = cap || push_ok;
  assign ctrl_req = (state_q == S_REPLY) || (state_q == S_INSERT && ins_need_q);
  assign emit_req = ctrl_req || chain_emit.req;
  assign push     = emit_req && !cap && push_ok;
  // Hold the probe while its cell's result cannot be stored.
  assign adv      = !(chain_emit.req && !emit_ok);

  always_comb begin
    emit_word      = '0;
    if (state_q == S_REPLY) begin
      emit_word.event_kind = hmt_pkg::EV_REPLY;
      emit_word.dest_id    = item_q.sender_id;
      emit_word.dest_port  = item_q.sender_port;
      emit_word.beat_value = own_beat_q;
    end else if (state_q == S_INSERT) begin
      emit_word.event_kind = hmt_pkg::EV_ADDED;
      emit_word.dest_id    = ins.id;
      emit_word.dest_port  = ins.port;
    end else begin
      emit_word.event_kind = chain_emit.kind;
      emit_word.dest_id    = chain_emit.id;
      emit_word.dest_port  = chain_emit.port;
      emit_word.beat_value = (chain_emit.kind == hmt_pkg::EV_BEAT) ? own_beat_q : 32'd0;
    end
  end

  always_comb begin
    ins.en   = (state_q == S_INSERT) && ins_need_q && emit_ok;
    ins.id   = tick_q ? own_id_q : item_q.sender_id;
    ins.port = tick_q ? own_port_q : item_q.sender_port;
    ins.beat = tick_q ? own_beat_q : item_q.sender_heartbeat;
  end

  assign fin = (state_q == S_FIN) && fin_ok;

  hmt_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_word_i (emit_word),
    .fin_i       (fin),
    .push_ok_o   (push_ok),
    .fin_ok_o    (fin_ok),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o),
    .out_stall_i (out_stall_i)
  );

  // ---------------- sequencer ----------------
  assign in_stall_o = state_q != S_IDLE;
  assign accept     = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    state_d    = state_q;
    launched_d = launched_q;
    ins_need_d = ins_need_q;
    time_d     = time_q;
    own_beat_d = own_beat_q;
    in_group_d = in_group_q;
    if (probe[0].valid && adv) begin
      launched_d = 1'b1;
    end
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          launched_d = 1'b0;
          case (in_word_i.opcode)
            hmt_pkg::OP_JOIN_REQ: state_d = S_REPLY;
            hmt_pkg::OP_JOIN_REP: begin
              in_group_d = 1'b1;
              state_d    = S_SEARCH;
            end
            hmt_pkg::OP_HEARTBEAT: state_d = S_SEARCH;
            default: begin
              // advance time, saturating
              if (time_q != '1) begin
                time_d = time_q + 32'd1;
              end
              state_d = (in_group_q || intro_q) ? S_EXPIRE : S_FIN;
            end
          endcase
        end
      end
      S_REPLY: begin
        if (emit_ok) begin
          state_d = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (probe[TableDepth].valid) begin
          ins_need_d = !probe[TableDepth].found && probe[TableDepth].free_seen;
          launched_d = 1'b0;
          state_d    = S_INSERT;
        end
      end
      S_INSERT: begin
        if (!ins_need_q || emit_ok) begin
          state_d = tick_q ? S_BEAT : S_FIN;
        end
      end
      S_EXPIRE: begin
        if (probe[TableDepth].valid) begin
          // bump own heartbeat before recording it
          if (own_beat_q != '1) begin
            own_beat_d = own_beat_q + 32'd1;
          end
          launched_d = 1'b0;
          state_d    = S_SEARCH;
        end
      end
      S_BEAT: begin
        if (probe[TableDepth].valid && adv) begin
          launched_d = 1'b0;
          state_d    = S_FIN;
        end
      end
      S_FIN: begin
        if (fin_ok) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      launched_q <= 1'b0;
      ins_need_q <= 1'b0;
      cnt_q      <= '0;
      time_q     <= '0;
      own_beat_q <= '0;
      in_group_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      launched_q <= launched_d;
      ins_need_q <= ins_need_d;
      time_q     <= time_d;
      own_beat_q <= own_beat_d;
      in_group_q <= in_group_d;
      if (accept) begin
        cnt_q <= '0;
      end else if (emit_req && !cap && emit_ok) begin
        cnt_q <= cnt_q + hmt_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_word_i;
      tick_q <= in_word_i.opcode == hmt_pkg::OP_TICK;
    end
  end

  // ---------------- checks ----------------
  a_one_probe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(probe_vec))
    else $error("more than one probe in the chain");

  a_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= hmt_pkg::CNT_W'(hmt_pkg::MAX_RESULTS))
    else $error("result count beyond limit");

  a_idle_no_probe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (probe_vec == '0))
    else $error("probe left in chain while idle");

  a_no_push_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !emit_req)
    else $error("result requested while idle");

endmodule
`default_nettype wire

/* sv/hmt_cell.sv */
// One member slot of the table with its probe register.
`default_nettype none
module hmt_cell (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  adv_i,
  input  hmt_pkg::probe_t      probe_i,
  output hmt_pkg::probe_t      probe_o,
  input  wire [31:0]           time_i,
  input  wire [15:0]           timeout_i,
  input  hmt_pkg::insert_t     ins_i,
  output hmt_pkg::emit_t       emit_o
);

  logic            valid_q, valid_d;
  logic            cand_q, cand_d;
  logic [31:0]     id_q, beat_q, stamp_q;
  logic [15:0]     port_q;
  hmt_pkg::probe_t probe_q, probe_d;
  logic            probe_vq;
  logic            hit, old;
  logic [31:0]     age;
  logic            upd;

  assign hit = valid_q && (id_q == probe_i.id) && (port_q == probe_i.port);
  assign age = (time_i >= stamp_q) ? (time_i - stamp_q) : 32'd0;
  assign old = age > {16'd0, timeout_i};
  assign upd = adv_i && probe_i.valid && (probe_i.mode == hmt_pkg::MODE_SEARCH)
               && hit && !probe_i.found && (probe_i.beat > beat_q);

  always_comb begin
    probe_d = probe_i;
    valid_d = valid_q;
    cand_d  = cand_q;
    emit_o  = '0;
    emit_o.id   = id_q;
    emit_o.port = port_q;
    if (probe_i.valid) begin
      case (probe_i.mode)
        hmt_pkg::MODE_SEARCH: begin
          probe_d.found     = probe_i.found | hit;
          probe_d.free_seen = probe_i.free_seen | !valid_q;
          if (adv_i) begin
            cand_d = !valid_q && !probe_i.free_seen;
          end
        end
        hmt_pkg::MODE_EXPIRE: begin
          if (valid_q && old) begin
            emit_o.req  = 1'b1;
            emit_o.kind = hmt_pkg::EV_REMOVED;
            if (adv_i) begin
              valid_d = 1'b0;
            end
          end
        end
        hmt_pkg::MODE_BEAT: begin
          if (valid_q && !hit) begin
            emit_o.req  = 1'b1;
            emit_o.kind = hmt_pkg::EV_BEAT;
          end
        end
        default: begin
        end
      endcase
    end
    if (ins_i.en && cand_q) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      cand_q   <= 1'b0;
      probe_vq <= 1'b0;
    end else begin
      valid_q <= valid_d;
      cand_q  <= cand_d;
      if (adv_i) begin
        probe_vq <= probe_d.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      probe_q <= probe_d;
    end
    if (ins_i.en && cand_q) begin
      id_q    <= ins_i.id;
      port_q  <= ins_i.port;
      beat_q  <= ins_i.beat;
      stamp_q <= time_i;
    end else if (upd) begin
      beat_q  <= probe_i.beat;
      stamp_q <= time_i;
    end
  end

  always_comb begin
    probe_o       = probe_q;
    probe_o.valid = probe_vq;
  end

endmodule
`default_nettype wire

/* sv/hmt_out_stage.sv */
// Result hold-back and output register; sets the last flag.
`default_nettype none
module hmt_out_stage (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  push_i,
  input  hmt_pkg::out_word_t   push_word_i,
  input  wire                  fin_i,
  output logic                 push_ok_o,
  output logic                 fin_ok_o,
  output logic                 out_valid_o,
  output hmt_pkg::out_word_t   out_word_o,
  input  wire                  out_stall_i
);

  localparam int WordW = $bits(hmt_pkg::out_word_t);

  logic               pend_vq, out_vq;
  hmt_pkg::out_word_t pend_q, out_q;
  logic               out_free;

  assign out_free  = !out_vq || !out_stall_i;
  assign push_ok_o = !pend_vq || out_free;
  assign fin_ok_o  = push_ok_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_vq <= 1'b0;
      out_vq  <= 1'b0;
    end else begin
      if (push_i) begin
        pend_vq <= 1'b1;
        if (pend_vq) begin
          out_vq <= 1'b1;
        end else if (!out_stall_i) begin
          out_vq <= 1'b0;
        end
      end else if (fin_i && pend_vq) begin
        pend_vq <= 1'b0;
        out_vq  <= 1'b1;
      end else if (!out_stall_i) begin
        out_vq <= 1'b0;
      end
    end
  end

  // Clear last on entry; set it only when the whole message or tick finishes.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      pend_q <= {push_word_i[WordW-1:1], 1'b0};
      if (pend_vq) begin
        out_q <= {pend_q[WordW-1:1], 1'b0};
      end
    end else if (fin_i && pend_vq) begin
      out_q <= {pend_q[WordW-1:1], 1'b1};
    end
  end

  assign out_valid_o = out_vq;
  assign out_word_o  = out_q;

endmodule
`default_nettype wire
